>>> design/greedy_text_full_justifier_assert.svh
// Assertion macros for the justifier datapath.
`ifndef GREEDY_TEXT_FULL_JUSTIFIER_ASSERT_SVH
`define GREEDY_TEXT_FULL_JUSTIFIER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define GTFJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside reset.
`define GTFJ_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

>>> design/gtfj_pkg.sv
// Package with shared types and constants of the text justifier.
package gtfj_pkg;
  localparam int DEF_MAX_WIDTH = 32;
  localparam int DEF_MAX_WORDS = 16;
  localparam int CFG_W = 6;
  localparam int CH_W = 8;
  localparam logic [CH_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CFG_W-1:0] LW_RESET = 6'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_COPY,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic store_char;
    logic copy_step;
    logic take_word;
    logic div_init;
    logic div_step;
    logic emit_init;
    logic emit_step;
    logic last;
  } cmd_t;

  typedef struct packed {
    logic flush_need;
    logic copy_last;
    logic div_done;
    logic emit_last;
    logic out_free;
  } sts_t;
endpackage

>>> design/gtfj_ctrl.sv
// Controller state machine of the text justifier.
module gtfj_ctrl import gtfj_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic word_end_i,
  input  logic text_end_i,
  input  sts_t sts_i,
  output logic in_stall_o,
  output cmd_t cmd_o
);
  state_e state_q, state_d;
  logic tend_q, tend_d;
  logic last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tend_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tend_q <= tend_d;
      last_q <= last_d;
    end
  end

  always_comb begin
    state_d = state_q;
    tend_d = tend_q;
    last_d = last_q;
    cmd_o = '0;
    cmd_o.last = last_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.store_char = 1'b1;
          if (word_end_i || text_end_i) begin
            tend_d = text_end_i;
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sts_i.flush_need) begin
          cmd_o.div_init = 1'b1;
          cmd_o.last = 1'b0;
          last_d = 1'b0;
          state_d = ST_DIV;
        end else begin
          state_d = ST_COPY;
        end
      end
      ST_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.copy_last) begin
          cmd_o.take_word = 1'b1;
          if (tend_q) begin
            cmd_o.div_init = 1'b1;
            cmd_o.last = 1'b1;
            last_d = 1'b1;
            state_d = ST_DIV;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.emit_init = 1'b1;
          state_d = ST_EMIT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) begin
            if (last_q) begin
              tend_d = 1'b0;
              last_d = 1'b0;
              state_d = ST_IDLE;
            end else begin
              state_d = ST_COPY;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

>>> design/gtfj_dp.sv
// Datapath of the text justifier: word buffers, gap divider and line emitter.
module gtfj_dp import gtfj_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_WORDS = DEF_MAX_WORDS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic [CH_W-1:0] ch_i,
  input  cmd_t            cmd_i,
  output sts_t            sts_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [CH_W-1:0] out_ch_o,
  output logic            line_end_o,
  output logic            text_done_o,
  output logic            overflow_o
);
  `include "greedy_text_full_justifier_assert.svh"

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int IW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int SW = WW + CW + 2;

  logic [CH_W-1:0] pw_q [MAX_WIDTH];
  logic [CH_W-1:0] lc_q [MAX_WIDTH];
  logic [WW-1:0]   wl_q [MAX_WORDS];

  logic [CFG_W-1:0] lw_q;
  logic [WW-1:0] plen_q, cidx_q, lett_q, base_q, rem_q;
  logic [WW-1:0] pos_q, krem_q, grem_q, src_q;
  logic [CW-1:0] cnt_q, wi_q;
  logic ptrunc_q, ovf_q, triv_q, last_q;
  logic ov_q;
  logic [CH_W-1:0] och_q;
  logic ole_q, otd_q, oov_q;

  logic [WW-1:0] w;
  logic [CW-1:0] gaps;
  logic [SW-1:0] need;
  logic out_free, gap_more;
  logic [CH_W-1:0] ech;
  logic [WW-1:0] gap_len;

  always_comb begin
    if (lw_q == '0) begin
      w = WW'(1);
    end else if (lw_q > CFG_W'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(lw_q);
    end
  end

  assign gaps = (cnt_q != '0) ? cnt_q - CW'(1) : '0;
  assign need = SW'(lett_q) + SW'(cnt_q) + SW'(plen_q);
  assign out_free = !ov_q || !out_stall_i;
  assign gap_more = (CW'(wi_q) + CW'(1)) < cnt_q;
  assign gap_len = base_q + ((WW'(wi_q) < rem_q) ? WW'(1) : WW'(0));
  assign ech = (krem_q != '0) ? lc_q[src_q[AW-1:0]] : SPACE_CHAR;

  always_comb begin
    sts_o.flush_need = (cnt_q != '0) &&
                       ((cnt_q >= CW'(MAX_WORDS)) || (need > SW'(w)));
    sts_o.copy_last = (cidx_q == plen_q - WW'(1));
    sts_o.div_done = triv_q || (rem_q < WW'(gaps));
    sts_o.emit_last = (pos_q == w - WW'(1));
    sts_o.out_free = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_char && plen_q < w) begin
      pw_q[plen_q[AW-1:0]] <= ch_i;
    end
    if (cmd_i.copy_step && lett_q < WW'(MAX_WIDTH)) begin
      lc_q[lett_q[AW-1:0]] <= pw_q[cidx_q[AW-1:0]];
    end
    if (cmd_i.take_word) begin
      wl_q[cnt_q[IW-1:0]] <= plen_q;
    end
    if (cmd_i.emit_step) begin
      och_q <= ech;
      ole_q <= sts_o.emit_last;
      otd_q <= sts_o.emit_last && last_q;
      oov_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lw_q <= LW_RESET;
      plen_q <= '0;
      cidx_q <= '0;
      lett_q <= '0;
      cnt_q <= '0;
      ptrunc_q <= 1'b0;
      ovf_q <= 1'b0;
      base_q <= '0;
      rem_q <= '0;
      triv_q <= 1'b0;
      last_q <= 1'b0;
      pos_q <= '0;
      wi_q <= '0;
      krem_q <= '0;
      grem_q <= '0;
      src_q <= '0;
      ov_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lw_q <= cfg_data_i;
      end
      if (cmd_i.store_char) begin
        if (plen_q < w) begin
          plen_q <= plen_q + WW'(1);
        end else begin
          ptrunc_q <= 1'b1;
        end
      end
      if (cmd_i.copy_step) begin
        if (lett_q < WW'(MAX_WIDTH)) begin
          lett_q <= lett_q + WW'(1);
        end
        cidx_q <= cmd_i.take_word ? '0 : cidx_q + WW'(1);
      end
      if (cmd_i.take_word) begin
        cnt_q <= cnt_q + CW'(1);
        ovf_q <= ovf_q | ptrunc_q;
        plen_q <= '0;
        ptrunc_q <= 1'b0;
      end
      if (cmd_i.div_init) begin
        last_q <= cmd_i.last;
        if (cmd_i.last || gaps == '0 || (SW'(lett_q) + SW'(gaps)) > SW'(w)) begin
          triv_q <= 1'b1;
          base_q <= WW'(1);
          rem_q <= '0;
        end else begin
          triv_q <= 1'b0;
          base_q <= '0;
          rem_q <= w - lett_q;
        end
      end
      if (cmd_i.div_step) begin
        rem_q <= rem_q - WW'(gaps);
        base_q <= base_q + WW'(1);
      end
      if (cmd_i.emit_init) begin
        pos_q <= '0;
        wi_q <= '0;
        src_q <= '0;
        grem_q <= '0;
        krem_q <= (cnt_q != '0) ? wl_q[0] : '0;
      end
      if (out_free) begin
        ov_q <= cmd_i.emit_step;
      end
      if (cmd_i.emit_step) begin
        pos_q <= pos_q + WW'(1);
        if (krem_q != '0) begin
          src_q <= src_q + WW'(1);
          krem_q <= krem_q - WW'(1);
          if (krem_q == WW'(1) && gap_more) begin
            grem_q <= gap_len;
          end
        end else if (grem_q != '0) begin
          grem_q <= grem_q - WW'(1);
          if (grem_q == WW'(1)) begin
            wi_q <= wi_q + CW'(1);
            krem_q <= wl_q[IW'(wi_q + CW'(1))];
          end
        end
        if (sts_o.emit_last) begin
          cnt_q <= '0;
          lett_q <= '0;
          ovf_q <= 1'b0;
        end
      end
    end
  end

  assign out_valid_o = ov_q;
  assign out_ch_o = och_q;
  assign line_end_o = ole_q;
  assign text_done_o = otd_q;
  assign overflow_o = oov_q;

  `GTFJ_NEVER(a_cnt_max, cnt_q > CW'(MAX_WORDS), "word count above limit")
  `GTFJ_NEVER(a_lett_max, lett_q > WW'(MAX_WIDTH), "held letters above limit")
  `GTFJ_ASSERT(a_emit_valid, cmd_i.emit_step |=> ov_q, "emitted character not presented")
endmodule

>>> design/greedy_text_full_justifier.sv
// Top level of the greedy full text justifier.
//  channel  | direction | signals
//  input    | in        | in_valid_i, in_stall_o, ch_i, word_end_i, text_end_i
//  output   | out       | out_valid_o, out_stall_i, out_ch_o, line_end_o, text_done_o, overflow_o
//  config   | in        | cfg_we_i, cfg_data_i
// A character that does not close a word is stored in the word buffer.
// A closing character starts a check, the copy of the word's letters into the line and,
// per emitted line of width w, the repeated-subtraction gap divider and the emitter.
// Reset empties the line and sets the width to 16; no clearing pass is needed.
// Output stalls hold the emitter; the input is stalled while any of this work runs.
module greedy_text_full_justifier import gtfj_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_WORDS = DEF_MAX_WORDS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CH_W-1:0]  ch_i,
  input  logic             word_end_i,
  input  logic             text_end_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [CH_W-1:0]  out_ch_o,
  output logic             line_end_o,
  output logic             text_done_o,
  output logic             overflow_o
);
  cmd_t cmd;
  sts_t sts;

  gtfj_ctrl u_ctrl (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .word_end_i(word_end_i),
    .text_end_i(text_end_i),
    .sts_i(sts),
    .in_stall_o(in_stall_o),
    .cmd_o(cmd)
  );

  gtfj_dp #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_WORDS(MAX_WORDS)
  ) u_dp (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .ch_i(ch_i),
    .cmd_i(cmd),
    .sts_o(sts),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_ch_o(out_ch_o),
    .line_end_o(line_end_o),
    .text_done_o(text_done_o),
    .overflow_o(overflow_o)
  );
endmodule
